// ----- design/tvts_pkg.sv -----
// Shared constants for the tolerant vector table search block.
// Field widths, register codes, stream packing sizes and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tvts_pkg;

  localparam int TOL_W          = 31;
  localparam int LEN_W          = 5;
  localparam int DIM_W          = 3;
  localparam int IDX_FIELD_W    = 4;
  localparam int FIELD_W        = 32;
  localparam int IN_VALUES      = 4;

  localparam int DEF_MAX_ENTRIES  = 16;
  localparam int DEF_VECTOR_LANES = 4;
  localparam int DEF_VALUE_BITS   = 32;

  localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIST_LENGTH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_VECTOR_DIM  = 2'd2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam int S_TDATA_RAW = IDX_FIELD_W + IN_VALUES * FIELD_W;
  localparam int S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((IDX_FIELD_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- design/tvts_store.sv -----
// Vector table memory: one row holds all lanes of one entry.
// One write port and one registered read port with read enable; uses no package.
`timescale 1ns / 1ps
`default_nettype none

module tvts_store #(
  parameter int MAX_ENTRIES = 16,
  parameter int ROW_W       = 128,
  parameter int IDX_W       = 4
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_addr_i,
  input  wire logic [ROW_W-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_addr_i,
  output logic      [ROW_W-1:0] rd_data_o
);

  logic [ROW_W-1:0] mem_q [MAX_ENTRIES];
  logic [ROW_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- design/tvts_cmp.sv -----
// Row comparator: tests every enabled lane of a stored row against the query.
// Each lane checks |entry - query| < tolerance at one extra bit; uses tvts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tvts_cmp #(
  parameter int VECTOR_LANES = 4,
  parameter int VALUE_BITS   = 32
) (
  input  wire logic [VECTOR_LANES*VALUE_BITS-1:0] row_i,
  input  wire logic [VECTOR_LANES*VALUE_BITS-1:0] query_i,
  input  wire logic [tvts_pkg::TOL_W-1:0]         tolerance_i,
  input  wire logic [tvts_pkg::DIM_W-1:0]         vector_dim_i,
  output logic                                    hit_o
);

  import tvts_pkg::*;

  localparam int CMP_W = (VALUE_BITS + 1 > TOL_W) ? VALUE_BITS + 1 : TOL_W;

  always_comb begin
    logic signed [VALUE_BITS:0] ent;
    logic signed [VALUE_BITS:0] qry;
    logic signed [VALUE_BITS:0] dpos;
    logic signed [VALUE_BITS:0] dneg;
    logic        [VALUE_BITS:0] mag;
    logic                       lane_ok;
    hit_o = 1'b1;
    for (int k = 0; k < VECTOR_LANES; k++) begin
      ent     = signed'({row_i[k*VALUE_BITS+VALUE_BITS-1], row_i[k*VALUE_BITS +: VALUE_BITS]});
      qry     = signed'({query_i[k*VALUE_BITS+VALUE_BITS-1],
                         query_i[k*VALUE_BITS +: VALUE_BITS]});
      dpos    = ent - qry;
      dneg    = qry - ent;
      mag     = dpos[VALUE_BITS] ? dneg : dpos;
      lane_ok = CMP_W'(mag) < CMP_W'(tolerance_i);
      if ((k < int'(vector_dim_i)) && !lane_ok) begin
        hit_o = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/tolerant_vector_table_search.sv -----
// Top level: configuration registers, scan sequencer and result register.
// Depends on tvts_pkg, tvts_store and tvts_cmp. A write transaction is stored at its accept edge.
// A search reads one entry per cycle; an untaken result holds a search at its end. A match on
// entry m raises m_axis_tvalid once the registered row of entry m is compared, no match once
// min(list_length, MAX_ENTRIES) entries are read; s_axis_tready returns with m_axis_tvalid.
// Reset clears control state and sets tolerance 0, list_length 0, vector_dim 4.
`timescale 1ns / 1ps
`default_nettype none

module tolerant_vector_table_search #(
  parameter int MAX_ENTRIES  = tvts_pkg::DEF_MAX_ENTRIES,
  parameter int VECTOR_LANES = tvts_pkg::DEF_VECTOR_LANES,
  parameter int VALUE_BITS   = tvts_pkg::DEF_VALUE_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tvts_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [tvts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: entry_index[3:0], value_0, value_1, value_2, value_3, zero pad.
  input  wire logic [tvts_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // Fields: operation.
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // Fields from bit 0: match_index[3:0], zero pad.
  output logic [tvts_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // Fields: found.
  output logic                                m_axis_tuser
);

  import tvts_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int EXT_W = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;
  localparam int ROW_W = VECTOR_LANES * VALUE_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic [TOL_W-1:0] tol_q;
  logic [LEN_W-1:0] len_q;
  logic [DIM_W-1:0] dim_q;

  logic             state_q, state_d;
  logic [CNT_W-1:0] rd_cnt_q, rd_cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic [ROW_W-1:0] qry_q, qry_d;
  logic             m_valid_q, m_valid_d;
  logic             m_found_q;
  logic [IDX_W-1:0] m_idx_q;

  logic             in_acc;
  logic [EXT_W-1:0] wr_idx_ext;
  logic             wr_en;
  logic [CNT_W-1:0] len_eff;
  logic             rd_en;
  logic [ROW_W-1:0] row;
  logic             row_hit;
  logic             hit;
  logic             exhausted;
  logic             fin;
  logic             out_free;
  logic             load_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
      len_q <= '0;
      dim_q <= DIM_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_TOLERANCE:   tol_q <= cfg_data_i[TOL_W-1:0];
        CFG_LIST_LENGTH: len_q <= cfg_data_i[LEN_W-1:0];
        CFG_VECTOR_DIM:  dim_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    qry_d = '0;
    for (int j = 0; j < VECTOR_LANES; j++) begin
      if (j < IN_VALUES) begin
        qry_d[j*VALUE_BITS +: VALUE_BITS] =
          VALUE_BITS'(signed'(s_axis_tdata[IDX_FIELD_W + j*FIELD_W +: FIELD_W]));
      end
    end
  end

  assign wr_idx_ext = EXT_W'(s_axis_tdata[IDX_FIELD_W-1:0]);
  assign wr_en      = in_acc && (s_axis_tuser == OP_WRITE) && (int'(wr_idx_ext) < MAX_ENTRIES);
  assign len_eff    = (int'(len_q) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(len_q);

  tvts_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ROW_W       (ROW_W),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_idx_ext[IDX_W-1:0]),
    .wr_data_i (qry_d),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_cnt_q[IDX_W-1:0]),
    .rd_data_o (row)
  );

  tvts_cmp #(
    .VECTOR_LANES (VECTOR_LANES),
    .VALUE_BITS   (VALUE_BITS)
  ) u_cmp (
    .row_i        (row),
    .query_i      (qry_q),
    .tolerance_i  (tol_q),
    .vector_dim_i (dim_q),
    .hit_o        (row_hit)
  );

  assign hit       = cmp_vld_q && row_hit;
  assign exhausted = !cmp_vld_q && (rd_cnt_q == len_eff);
  assign fin       = (state_q == ST_SCAN) && (hit || exhausted);
  assign out_free  = !m_valid_q || m_axis_tready;
  assign load_out  = fin && out_free;
  assign rd_en     = (state_q == ST_SCAN) && !hit && (rd_cnt_q < len_eff);

  always_comb begin
    state_d   = state_q;
    rd_cnt_d  = rd_cnt_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    m_valid_d = m_axis_tready ? 1'b0 : m_valid_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser == OP_SEARCH)) begin
          state_d  = ST_SCAN;
          rd_cnt_d = '0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_cnt_d  = rd_cnt_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_cnt_q[IDX_W-1:0];
        end else if (fin && !out_free) begin
          cmp_vld_d = cmp_vld_q;
        end
        if (load_out) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qry_q <= qry_d;
    end
    if (load_out) begin
      m_found_q <= hit;
      m_idx_q   <= hit ? cmp_idx_q : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(IDX_FIELD_W'(m_idx_q));
  assign m_axis_tuser  = m_found_q;

endmodule

`default_nettype wire

// ----- test/tolerant_vector_table_search_test.sv -----
// Self-checking testbench for the tolerant vector table search block.
// A scoreboard class predicts each search result and checks the result stream.
// Depends on tvts_pkg and the tolerant_vector_table_search top level.
`timescale 1ns / 1ps

module tolerant_vector_table_search_test;
  import tvts_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES          = 13;
  localparam int PHASE_ITEMS     = 130;

  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [FIELD_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] Q_NEG1 = 32'hFFFF_FFFF;
  localparam logic [TOL_W-1:0]   TOL_MAX = '1;

  typedef logic [DEF_VECTOR_LANES-1:0][FIELD_W-1:0] lanes_t;

  typedef struct packed {
    logic                   op;
    logic [IDX_FIELD_W-1:0] entry;
    lanes_t                 lanes;
  } vec_item_t;

  typedef struct {
    logic                   found;
    logic [IDX_FIELD_W-1:0] match_index;
  } match_t;

  class table_search_scoreboard;
    lanes_t           vectors [DEF_MAX_ENTRIES];
    logic [TOL_W-1:0] tolerance;
    logic [LEN_W-1:0] list_length;
    logic [DIM_W-1:0] vector_dim;
    match_t           pending_matches [$];
    int               errors;

    function new();
      tolerance   = '0;
      list_length = '0;
      vector_dim  = DIM_RESET;
      errors      = 0;
    endfunction

    function void note_config(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        CFG_TOLERANCE: begin
          tolerance = data[TOL_W-1:0];
        end
        CFG_LIST_LENGTH: begin
          list_length = data[LEN_W-1:0];
        end
        CFG_VECTOR_DIM: begin
          vector_dim = data[DIM_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Strict test on the exact signed difference, so no wraparound can occur.
    function bit lane_close(logic [FIELD_W-1:0] stored, logic [FIELD_W-1:0] query);
      longint diff;
      diff = longint'($signed(stored)) - longint'($signed(query));
      if (diff < 0) diff = -diff;
      return diff < longint'(tolerance);
    endfunction

    function void note_item(logic op, logic [S_TDATA_W-1:0] tdata);
      logic [IDX_FIELD_W-1:0] entry;
      lanes_t lanes;
      match_t m;
      int len_eff;
      int dim_eff;
      int i;
      int k;
      bit hit;
      entry = tdata[IDX_FIELD_W-1:0];
      lanes = tdata[IDX_FIELD_W +: IN_VALUES*FIELD_W];
      if (op == OP_WRITE) begin
        vectors[entry] = lanes;
        return;
      end
      len_eff = (list_length > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(list_length);
      dim_eff = (vector_dim > DEF_VECTOR_LANES) ? DEF_VECTOR_LANES : int'(vector_dim);
      m.found = 1'b0;
      m.match_index = '0;
      for (i = 0; i < len_eff && !m.found; i++) begin
        hit = 1'b1;
        for (k = 0; k < dim_eff; k++) begin
          if (!lane_close(vectors[i][k], lanes[k])) hit = 1'b0;
        end
        if (hit) begin
          m.found = 1'b1;
          m.match_index = IDX_FIELD_W'(i);
        end
      end
      pending_matches.push_back(m);
    endfunction

    function void check_match(logic found, logic [IDX_FIELD_W-1:0] match_index);
      match_t m;
      if (pending_matches.size() == 0) begin
        $display("%0t: unexpected result, found %0d match_index %0d",
                 $time, found, match_index);
        errors++;
        return;
      end
      m = pending_matches.pop_front();
      if (found !== m.found) begin
        $display("%0t: found mismatch, expected %0d, actual %0d", $time, m.found, found);
        errors++;
      end
      if (match_index !== m.match_index) begin
        $display("%0t: match_index mismatch, expected %0d, actual %0d",
                 $time, m.match_index, match_index);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // Fields from bit 0: entry_index[3:0], value_0, value_1, value_2, value_3, zero pad.
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  // Fields: operation.
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // Fields from bit 0: match_index[3:0], zero pad.
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  // Fields: found.
  logic                  m_axis_tuser;

  bit steady_sender;
  bit hold_off_req;

  table_search_scoreboard sb = new();

  tolerant_vector_table_search uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_match(m_axis_tuser, m_axis_tdata[IDX_FIELD_W-1:0]);
    end
    if (cfg_valid_i && cfg_ready_o) begin
      sb.note_config(cfg_addr_i, cfg_data_i);
    end
    if (s_axis_tvalid && s_axis_tready) begin
      sb.note_item(s_axis_tuser, s_axis_tdata);
    end
  end

  function automatic vec_item_t item(logic op, logic [IDX_FIELD_W-1:0] entry,
                                     logic [FIELD_W-1:0] v0, logic [FIELD_W-1:0] v1,
                                     logic [FIELD_W-1:0] v2, logic [FIELD_W-1:0] v3);
    vec_item_t it;
    it.op    = op;
    it.entry = entry;
    it.lanes = {v3, v2, v1, v0};
    return it;
  endfunction

  function automatic logic [FIELD_W-1:0] corner_value();
    case ($urandom_range(0, 4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return Q_NEG1;
      default: return $urandom();
    endcase
  endfunction

  // Values around a stored element, often right on or just inside the tolerance edge.
  function automatic logic [FIELD_W-1:0] near_value(logic [FIELD_W-1:0] base,
                                                    logic [TOL_W-1:0] tol);
    int span;
    int offset;
    if (tol > 31'd1048576) begin
      if ($urandom_range(0, 1) == 0) return base;
      return $urandom();
    end
    span = int'(tol);
    case ($urandom_range(0, 7))
      0: offset = span;
      1: offset = -span;
      2: offset = span - 1;
      3: offset = 1 - span;
      default: offset = int'($urandom_range(0, 2 * span + 2)) - (span + 1);
    endcase
    return base + offset;
  endfunction

  function automatic vec_item_t write_item();
    vec_item_t it;
    int r;
    int src;
    int k;
    it.op    = OP_WRITE;
    it.entry = IDX_FIELD_W'($urandom());
    r   = $urandom_range(0, 9);
    src = $urandom_range(0, DEF_MAX_ENTRIES - 1);
    for (k = 0; k < DEF_VECTOR_LANES; k++) begin
      if (r < 5) it.lanes[k] = $urandom();
      else if (r < 8) it.lanes[k] = near_value(sb.vectors[src][k], sb.tolerance);
      else it.lanes[k] = corner_value();
    end
    return it;
  endfunction

  function automatic vec_item_t search_item();
    vec_item_t it;
    int r;
    int len_eff;
    int src;
    int k;
    it.op    = OP_SEARCH;
    it.entry = IDX_FIELD_W'($urandom());
    r = $urandom_range(0, 19);
    len_eff = (sb.list_length > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(sb.list_length);
    src = $urandom_range(0, (len_eff == 0) ? DEF_MAX_ENTRIES - 1 : len_eff - 1);
    for (k = 0; k < DEF_VECTOR_LANES; k++) begin
      if (r < 2) it.lanes[k] = sb.vectors[src][k];
      else if (r < 14) it.lanes[k] = near_value(sb.vectors[src][k], sb.tolerance);
      else if (r < 17) it.lanes[k] = $urandom();
      else it.lanes[k] = corner_value();
    end
    return it;
  endfunction

  function automatic logic [TOL_W-1:0] pick_tolerance();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TOL_W'(1);
      2: return TOL_MAX;
      3, 4: return TOL_W'($urandom_range(2, 256));
      5, 6: return TOL_W'($urandom_range(256, 65536));
      7, 8: return TOL_W'($urandom_range(65536, 1048576));
      default: return TOL_W'($urandom());
    endcase
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_sender || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(vec_item_t it);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= S_TDATA_W'({it.lanes, it.entry});
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Waits until the block is idle, then writes every register with random upper bits.
  task automatic reconfigure(logic [TOL_W-1:0] tol, logic [LEN_W-1:0] len,
                             logic [DIM_W-1:0] dim, bit poke_unused);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_matches.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(CFG_TOLERANCE, {1'($urandom()), tol});
    write_reg(CFG_LIST_LENGTH, {27'($urandom()), len});
    write_reg(CFG_VECTOR_DIM, {29'($urandom()), dim});
    if (poke_unused) write_reg(CFG_UNUSED, $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int hold;
    int run;
    int r;
    run = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (run > 0) begin
        m_axis_tready <= 1'b1;
        run--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          m_axis_tready <= 1'b1;
        end else if (r < 80) begin
          m_axis_tready <= 1'b0;
        end else if (r < 93) begin
          m_axis_tready <= 1'b1;
          run = $urandom_range(10, 80);
        end else begin
          m_axis_tready <= 1'b0;
          hold = $urandom_range(5, 40);
          repeat (hold) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [TOL_W-1:0] tol;
    logic [LEN_W-1:0] len;
    logic [DIM_W-1:0] dim;
    vec_item_t it;
    int phase;
    int e;
    int k;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_WRITE;
    m_axis_tready = 1'b0;
    steady_sender = 1'b0;
    hold_off_req  = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty list, full-scale values, strict edges, zero and wide dimension.
    send_item(item(OP_SEARCH, 4'hF, '0, '0, '0, '0));
    reconfigure(TOL_MAX, 5'd3, 3'd4, 1'b1);
    send_item(item(OP_WRITE, 4'd0, Q_MAX, Q_MIN, '0, Q_NEG1));
    send_item(item(OP_WRITE, 4'd1, Q_MIN, Q_MAX, 32'd1, '0));
    send_item(item(OP_WRITE, 4'd2, '0, '0, '0, '0));
    send_item(item(OP_WRITE, 4'hF, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1));
    send_item(item(OP_SEARCH, 4'd0, Q_MAX, Q_MIN, '0, Q_NEG1));
    send_item(item(OP_SEARCH, 4'd0, '0, '0, '0, '0));
    send_item(item(OP_SEARCH, 4'hF, Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1));
    send_item(item(OP_SEARCH, 4'd5, Q_MIN, Q_MAX, 32'd1, '0));
    send_item(item(OP_SEARCH, 4'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    reconfigure('0, 5'd3, 3'd4, 1'b0);
    send_item(item(OP_SEARCH, 4'd0, Q_MAX, Q_MIN, '0, Q_NEG1));
    reconfigure('0, 5'd3, 3'd0, 1'b0);
    send_item(item(OP_SEARCH, 4'd0, $urandom(), $urandom(), $urandom(), $urandom()));
    reconfigure(TOL_W'(1), 5'd3, 3'd7, 1'b0);
    send_item(item(OP_SEARCH, 4'd1, Q_MIN, Q_MAX, 32'd1, '0));
    send_item(item(OP_SEARCH, 4'd1, Q_MIN, Q_MAX, 32'd1, 32'd1));
    reconfigure(TOL_W'(2), 5'd3, 3'd1, 1'b0);
    send_item(item(OP_SEARCH, 4'd0, 32'd1, Q_MAX, Q_MAX, Q_MAX));
    send_item(item(OP_SEARCH, 4'd0, Q_MIN + 32'd1, '0, '0, '0));
    send_item(item(OP_WRITE, 4'd1, '0, Q_NEG1, Q_NEG1, Q_NEG1));
    send_item(item(OP_SEARCH, 4'd0, 32'd1, '0, '0, '0));

    // Every entry gets written before any search reaches past entry 2.
    for (e = 0; e < DEF_MAX_ENTRIES; e++) begin
      it.op    = OP_WRITE;
      it.entry = IDX_FIELD_W'(e);
      for (k = 0; k < DEF_VECTOR_LANES; k++) it.lanes[k] = $urandom();
      send_item(it);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      tol = pick_tolerance();
      case (phase)
        0: begin
          len = 5'd31;
          dim = 3'd7;
        end
        1: begin
          len = 5'd17;
          dim = 3'd5;
        end
        2: begin
          len = 5'd16;
          dim = 3'd0;
        end
        3: begin
          len = 5'd0;
          dim = 3'd4;
        end
        default: begin
          case ($urandom_range(0, 9))
            0: len = 5'd0;
            1: len = 5'd1;
            2: len = 5'd16;
            3: len = 5'd31;
            default: len = LEN_W'($urandom_range(1, 16));
          endcase
          dim = ($urandom_range(0, 1) == 0) ? 3'd4 : DIM_W'($urandom());
        end
      endcase
      reconfigure(tol, len, dim, $urandom_range(0, 3) == 0);
      steady_sender = (phase == 1) || ($urandom_range(0, 3) == 0);
      if (phase == 1) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 35) send_item(write_item());
        else send_item(search_item());
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_matches.size() != 0) @(negedge clk_i);
    repeat (25) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_matches.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
